@@ src/sid_pkg.sv @@
package sid_pkg;

	// raw width of the operand and quotient fields on the channels
	localparam int FIELD_WIDTH = 64;
	localparam int DEFAULT_DATA_WIDTH = 64;

	// configuration port
	localparam int APB_ADDR_WIDTH = 3;
	localparam int APB_DATA_WIDTH = 32;
	localparam int REG_INDEX_WIDTH = APB_ADDR_WIDTH - 2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_ERROR_ON_ZERO_DIVISOR = 1'b0;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NULL     = 2'd1,
		ST_DIVZERO  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// side information that rides along the divider chain
	typedef struct packed {
		status_t status;
		logic    neg_q;
		logic    ovf_nonzero;
		logic    res_uns;
	} meta_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] quotient_bits;
		logic                   quotient_unsigned;
		status_t                status;
	} result_t;

endpackage

@@ src/sid_in_if.sv @@
interface sid_in_if;
	import sid_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] dividend_bits;
	logic                   dividend_unsigned;
	logic                   dividend_null;
	logic [FIELD_WIDTH-1:0] divisor_bits;
	logic                   divisor_unsigned;
	logic                   divisor_null;

	modport source (
		output valid, dividend_bits, dividend_unsigned, dividend_null,
		output divisor_bits, divisor_unsigned, divisor_null,
		input  ready
	);

	modport sink (
		input  valid, dividend_bits, dividend_unsigned, dividend_null,
		input  divisor_bits, divisor_unsigned, divisor_null,
		output ready
	);

endinterface

@@ src/sid_out_if.sv @@
interface sid_out_if;
	import sid_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] quotient_bits;
	logic                   quotient_unsigned;
	status_t                status;

	modport source (
		output valid, quotient_bits, quotient_unsigned, status,
		input  ready
	);

	modport sink (
		input  valid, quotient_bits, quotient_unsigned, status,
		output ready
	);

endinterface

@@ src/sid_prep.sv @@
module sid_prep #(
	parameter int W = sid_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic [W-1:0]     a,
	input  logic             a_uns,
	input  logic             a_null,
	input  logic [W-1:0]     b,
	input  logic             b_uns,
	input  logic             b_null,
	input  logic             err_zero,
	output logic [W-1:0]     am,
	output logic [W-1:0]     bm,
	output sid_pkg::meta_t   meta
);
	import sid_pkg::*;

	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

	logic a_neg;
	logic b_neg;
	logic res_uns;

	assign res_uns = a_uns | b_uns;
	assign a_neg   = ~a_uns & a[W-1];
	assign b_neg   = ~b_uns & b[W-1];
	assign am      = a_neg ? (~a + 1'b1) : a;
	assign bm      = b_neg ? (~b + 1'b1) : b;

	always_comb begin
		meta.res_uns     = res_uns;
		meta.neg_q       = ~res_uns & (a_neg ^ b_neg);
		meta.ovf_nonzero = res_uns & (a_neg | b_neg);
		if (a_null | b_null) begin
			meta.status = ST_NULL;
		end else if (b == '0) begin
			meta.status = err_zero ? ST_DIVZERO : ST_NULL;
		end else if (~res_uns && a == MIN_VAL && &b) begin
			meta.status = ST_OVERFLOW;
		end else begin
			meta.status = ST_OK;
		end
	end

endmodule

@@ src/sid_cell.sv @@
module sid_cell #(
	parameter int W = sid_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_in,
	input  logic [W-1:0]   rem_in,
	input  logic [W-1:0]   aq_in,
	input  logic [W-1:0]   bm_in,
	input  sid_pkg::meta_t meta_in,
	output logic           valid_out,
	output logic [W-1:0]   rem_out,
	output logic [W-1:0]   aq_out,
	output logic [W-1:0]   bm_out,
	output sid_pkg::meta_t meta_out
);
	import sid_pkg::*;

	logic [W:0]   trial;
	logic         fits;
	logic [W-1:0] rem_nxt;
	logic         valid_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] aq_q;
	logic [W-1:0] bm_q;
	meta_t        meta_q;

	// one restoring step: bring down the next dividend bit, try the divisor
	assign trial   = {rem_in, aq_in[W-1]} - {1'b0, bm_in};
	assign fits    = ~trial[W];
	assign rem_nxt = fits ? trial[W-1:0] : {rem_in[W-2:0], aq_in[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_nxt;
			aq_q   <= {aq_in[W-2:0], fits};
			bm_q   <= bm_in;
			meta_q <= meta_in;
		end
	end

	assign valid_out = valid_q;
	assign rem_out   = rem_q;
	assign aq_out    = aq_q;
	assign bm_out    = bm_q;
	assign meta_out  = meta_q;

endmodule

@@ src/sid_fixup.sv @@
module sid_fixup #(
	parameter int W = sid_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic [W-1:0]     qm,
	input  sid_pkg::meta_t   meta,
	output sid_pkg::result_t result
);
	import sid_pkg::*;

	logic [W-1:0] q_signed;
	status_t      status;

	assign q_signed = meta.neg_q ? (~qm + 1'b1) : qm;

	always_comb begin
		if (meta.status == ST_OK && meta.ovf_nonzero && |qm) begin
			status = ST_OVERFLOW;
		end else begin
			status = meta.status;
		end
		result.status            = status;
		result.quotient_unsigned = meta.res_uns;
		result.quotient_bits     = (status == ST_OK) ? FIELD_WIDTH'(q_signed) : '0;
	end

endmodule

@@ src/sql_integer_div_unit.sv @@
// sql integer DIV: one quotient item for each operand-pair item
//
// operands channel: an item is two raw operands, each tagged unsigned and
// null; only the low DATA_WIDTH bits of each operand take part
// result channel: quotient bits, result type and a status code
// (ok, null, division by zero, overflow)
// configuration: APB-style write of error_on_zero_divisor at byte address 0;
// a zero divisor then gives a division-by-zero status instead of null
//
// pipeline: the accepting edge loads the operand-prep stage register, then
// one restoring-division cell per quotient bit, then one output register;
// throughput one item per cycle while the skid register is empty, set by the
// chain of cells that each retire one quotient bit
// reset clears the valid bits of every stage, the output and skid
// registers, and the configuration register
// a stalled receiver holds the output register; one further item lands in
// the skid register, then the whole chain freezes and operands.ready falls
// until the receiver takes the held result
module sql_integer_div_unit #(
	parameter int DATA_WIDTH = sid_pkg::DEFAULT_DATA_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sid_in_if.sink                             operands,
	sid_out_if.source                          result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sid_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [sid_pkg::APB_DATA_WIDTH-1:0] pwdata,
	output logic [sid_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic                               pready
);
	import sid_pkg::*;

	localparam int W = DATA_WIDTH;

	// configuration register
	logic err_zero_q;
	logic reg_hit;

	// operand prep
	logic [W-1:0] am;
	logic [W-1:0] bm;
	meta_t        meta;

	// prep stage register
	logic         valid_s1;
	logic [W-1:0] am_s1;
	logic [W-1:0] bm_s1;
	meta_t        meta_s1;

	// chain wiring: index 0 is the prep stage, index k+1 the output of cell k
	logic         c_valid [W+1];
	logic [W-1:0] c_rem   [W+1];
	logic [W-1:0] c_aq    [W+1];
	logic [W-1:0] c_bm    [W+1];
	meta_t        c_meta  [W+1];

	result_t fixed;
	logic    en;
	logic    emerge;
	logic    out_free;

	// output and skid registers
	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_WIDTH-1:2] == REG_ERROR_ON_ZERO_DIVISOR);
	assign prdata  = reg_hit ? APB_DATA_WIDTH'(err_zero_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_zero_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			err_zero_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------- flow
	// the chain moves as one while the skid register is empty
	assign en             = ~skid_valid_q;
	assign operands.ready = en;

	// ---------------------------------------------------------------- prep
	sid_prep #(.W(W)) u_prep (
		.a        (operands.dividend_bits[W-1:0]),
		.a_uns    (operands.dividend_unsigned),
		.a_null   (operands.dividend_null),
		.b        (operands.divisor_bits[W-1:0]),
		.b_uns    (operands.divisor_unsigned),
		.b_null   (operands.divisor_null),
		.err_zero (err_zero_q),
		.am       (am),
		.bm       (bm),
		.meta     (meta)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1   <= am;
			bm_s1   <= bm;
			meta_s1 <= meta;
		end
	end

	// ---------------------------------------------------------------- cells
	// remainder starts at zero; dividend bits shift out of aq as quotient
	// bits shift in
	assign c_valid[0] = valid_s1;
	assign c_rem[0]   = '0;
	assign c_aq[0]    = am_s1;
	assign c_bm[0]    = bm_s1;
	assign c_meta[0]  = meta_s1;

	for (genvar k = 0; k < W; k++) begin : g_cell
		sid_cell #(.W(W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (c_valid[k]),
			.rem_in    (c_rem[k]),
			.aq_in     (c_aq[k]),
			.bm_in     (c_bm[k]),
			.meta_in   (c_meta[k]),
			.valid_out (c_valid[k+1]),
			.rem_out   (c_rem[k+1]),
			.aq_out    (c_aq[k+1]),
			.bm_out    (c_bm[k+1]),
			.meta_out  (c_meta[k+1])
		);
	end

	// sign correction and late overflow check on the finished quotient
	sid_fixup #(.W(W)) u_fixup (
		.qm     (c_aq[W]),
		.meta   (c_meta[W]),
		.result (fixed)
	);

	// ---------------------------------------------------------------- output
	assign emerge   = c_valid[W] & en;
	assign out_free = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= emerge;
			end
		end else if (emerge) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : fixed;
		end else if (emerge) begin
			skid_data_q <= fixed;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.quotient_bits     = out_data_q.quotient_bits;
	assign result.quotient_unsigned = out_data_q.quotient_unsigned;
	assign result.status            = out_data_q.status;

endmodule

@@ tb/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;

	// operand codes used in the directed rows
	localparam logic [FIELD_WIDTH-1:0] INT_MIN   = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
	localparam logic [FIELD_WIDTH-1:0] INT_MAX   = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
	localparam logic [FIELD_WIDTH-1:0] MINUS_ONE = {FIELD_WIDTH{1'b1}};
	localparam int DRAIN_CYCLES = DEFAULT_DATA_WIDTH + 10;
	localparam int NUM_DIRECTED = 24;

	// one operand-pair item as it goes onto the operands channel
	typedef struct packed {
		logic [FIELD_WIDTH-1:0] dividend_bits;
		logic                   dividend_unsigned;
		logic                   dividend_null;
		logic [FIELD_WIDTH-1:0] divisor_bits;
		logic                   divisor_unsigned;
		logic                   divisor_null;
	} operand_pair_t;

	// directed row: register setting, item, and a typed quotient where obvious
	typedef struct packed {
		logic          zero_err;
		operand_pair_t op;
		logic          typed;
		result_t       want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_WIDTH-1:0] paddr;
	logic [APB_DATA_WIDTH-1:0] pwdata;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;

	sid_in_if  operands();
	sid_out_if result();

	sql_integer_div_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands),
		.result   (result),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// quotients still owed by the block, oldest first
	result_t pending_quotients[$];
	// shadow of error_on_zero_divisor, as the block should hold it
	logic    zero_err_cfg;
	int      fail_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	// long receiver hold-off, counted down by the result sink
	int      hold_left;

	// directed items: extremes, signs, null and zero-divisor handling
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		// zero over one
		'{1'b0, '{64'd0, 1'b0, 1'b0, 64'd1, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_OK}},
		// signed truncation toward zero, all four sign mixes
		'{1'b0, '{64'd7, 1'b0, 1'b0, 64'd2, 1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, '{-64'd7, 1'b0, 1'b0, 64'd2, 1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, '{64'd7, 1'b0, 1'b0, -64'd2, 1'b0, 1'b0}, 1'b0, '0},
		'{1'b0, '{-64'd7, 1'b0, 1'b0, -64'd2, 1'b0, 1'b0}, 1'b0, '0},
		// most negative by minus one overflows
		'{1'b0, '{INT_MIN, 1'b0, 1'b0, MINUS_ONE, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_OVERFLOW}},
		'{1'b0, '{INT_MIN, 1'b0, 1'b0, 64'd1, 1'b0, 1'b0}, 1'b1, '{INT_MIN, 1'b0, ST_OK}},
		'{1'b0, '{INT_MIN, 1'b0, 1'b0, INT_MIN, 1'b0, 1'b0}, 1'b1, '{64'd1, 1'b0, ST_OK}},
		'{1'b0, '{INT_MAX, 1'b0, 1'b0, INT_MIN, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_OK}},
		// unsigned extremes
		'{1'b0, '{MINUS_ONE, 1'b1, 1'b0, 64'd1, 1'b1, 1'b0}, 1'b1, '{MINUS_ONE, 1'b1, ST_OK}},
		'{1'b0, '{MINUS_ONE, 1'b1, 1'b0, MINUS_ONE, 1'b1, 1'b0}, 1'b1, '{64'd1, 1'b1, ST_OK}},
		// unsigned dividend by signed minus one
		'{1'b0, '{INT_MIN, 1'b1, 1'b0, MINUS_ONE, 1'b0, 1'b0}, 1'b0, '0},
		// negative operand with an unsigned result: zero quotient is fine
		'{1'b0, '{-64'd1, 1'b0, 1'b0, 64'd5, 1'b1, 1'b0}, 1'b1, '{64'd0, 1'b1, ST_OK}},
		'{1'b0, '{-64'd10, 1'b0, 1'b0, 64'd5, 1'b1, 1'b0}, 1'b1, '{64'd0, 1'b1, ST_OVERFLOW}},
		'{1'b0, '{64'd10, 1'b1, 1'b0, -64'd5, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b1, ST_OVERFLOW}},
		// magnitude of the most negative value against the largest unsigned
		'{1'b0, '{INT_MIN, 1'b0, 1'b0, MINUS_ONE, 1'b1, 1'b0}, 1'b1, '{64'd0, 1'b1, ST_OK}},
		// zero divisor gives null while the register is clear
		'{1'b0, '{64'd5, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_NULL}},
		// null operands
		'{1'b0, '{64'd5, 1'b0, 1'b1, 64'd3, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_NULL}},
		'{1'b0, '{64'd5, 1'b1, 1'b0, 64'd3, 1'b1, 1'b1}, 1'b1, '{64'd0, 1'b1, ST_NULL}},
		// zero divisor reported as an error once the register is set
		'{1'b1, '{64'd5, 1'b0, 1'b0, 64'd0, 1'b1, 1'b0}, 1'b1, '{64'd0, 1'b1, ST_DIVZERO}},
		'{1'b1, '{64'd0, 1'b0, 1'b0, 64'd0, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_DIVZERO}},
		// null wins over a zero divisor; then both operands null, and a plain signed pair
		'{1'b1, '{64'd5, 1'b0, 1'b1, 64'd0, 1'b0, 1'b0}, 1'b1, '{64'd0, 1'b0, ST_NULL}},
		'{1'b1, '{MINUS_ONE, 1'b1, 1'b1, MINUS_ONE, 1'b1, 1'b1}, 1'b1, '{64'd0, 1'b1, ST_NULL}},
		'{1'b1, '{64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 64'hfedc_ba98_7654_3210, 1'b0, 1'b0},
			1'b0, '0}
	};

	// sql integer DIV of one operand pair under the given zero-divisor setting
	function automatic result_t predict_quotient(operand_pair_t p, logic zero_err);
		logic                   a_neg;
		logic                   b_neg;
		logic [FIELD_WIDTH-1:0] a_mag;
		logic [FIELD_WIDTH-1:0] b_mag;
		logic [FIELD_WIDTH-1:0] q_mag;
		result_t                r;
		r.quotient_bits     = '0;
		r.quotient_unsigned = p.dividend_unsigned | p.divisor_unsigned;
		r.status            = ST_OK;
		if (p.dividend_null || p.divisor_null) begin
			r.status = ST_NULL;
		end else if (p.divisor_bits == '0) begin
			r.status = zero_err ? ST_DIVZERO : ST_NULL;
		end else begin
			a_neg = !p.dividend_unsigned && p.dividend_bits[FIELD_WIDTH-1];
			b_neg = !p.divisor_unsigned && p.divisor_bits[FIELD_WIDTH-1];
			a_mag = a_neg ? -p.dividend_bits : p.dividend_bits;
			b_mag = b_neg ? -p.divisor_bits : p.divisor_bits;
			q_mag = a_mag / b_mag;
			if (!r.quotient_unsigned) begin
				if (p.dividend_bits == INT_MIN && p.divisor_bits == MINUS_ONE)
					r.status = ST_OVERFLOW;
				else
					r.quotient_bits = (a_neg != b_neg) ? -q_mag : q_mag;
			end else if ((a_neg || b_neg) && q_mag != '0) begin
				r.status = ST_OVERFLOW;
			end else begin
				r.quotient_bits = q_mag;
			end
		end
		return r;
	endfunction

	// operand spread over extremes, full-width noise and short magnitudes of both signs
	function automatic logic [FIELD_WIDTH-1:0] random_operand();
		logic [FIELD_WIDTH-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = 64'd1;
					2: v = INT_MIN;
					3: v = INT_MAX;
					default: v = MINUS_ONE;
				endcase
			end
			1, 2, 3: ;
			4, 5, 6: v = v >> $urandom_range(0, FIELD_WIDTH - 1);
			default: v = -(v >> $urandom_range(0, FIELD_WIDTH - 1));
		endcase
		return v;
	endfunction

	// mostly live operand pairs, now and then a null or a zero divisor
	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		p.dividend_bits     = random_operand();
		p.dividend_unsigned = 1'($urandom_range(0, 1));
		p.dividend_null     = ($urandom_range(0, 15) == 0);
		p.divisor_bits      = ($urandom_range(0, 19) == 0) ? '0 : random_operand();
		p.divisor_unsigned  = 1'($urandom_range(0, 1));
		p.divisor_null      = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// offer one item, with random gaps ahead of it; called and left at a rising edge
	task automatic send_pair(input operand_pair_t p, input logic typed, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			operands.valid <= 1'b0;
			@(posedge clk);
		end
		operands.valid             <= 1'b1;
		operands.dividend_bits     <= p.dividend_bits;
		operands.dividend_unsigned <= p.dividend_unsigned;
		operands.dividend_null     <= p.dividend_null;
		operands.divisor_bits      <= p.divisor_bits;
		operands.divisor_unsigned  <= p.divisor_unsigned;
		operands.divisor_null      <= p.divisor_null;
		do @(posedge clk); while (!operands.ready);
		// accepted at this edge: the register setting in force is the shadow
		pending_quotients.push_back(typed ? want : predict_quotient(p, zero_err_cfg));
	endtask

	// stop offering and wait until every owed quotient has come back
	task automatic drain_results();
		operands.valid <= 1'b0;
		while (pending_quotients.size() != 0)
			@(posedge clk);
	endtask

	// apb write, then a read back of the same register; back to back transfers
	task automatic write_register(input logic [REG_INDEX_WIDTH-1:0] idx,
			input logic [APB_DATA_WIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		zero_err_cfg = value[0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== value[0]) begin
			$error("register read back: expected %0d, actual %0d", value[0], prdata[0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// one random batch under one register setting and one idling pattern
	task automatic run_batch(input int n_items, input int idle_pct, input int stall_pct,
			input logic zero_err, input int hold);
		drain_results();
		write_register(REG_ERROR_ON_ZERO_DIVISOR, {{(APB_DATA_WIDTH-1){1'b0}}, zero_err});
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		hold_left      = hold;
		repeat (n_items)
			send_pair(random_pair(), 1'b0, '0);
	endtask

	// free-running clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// result sink: check the item taken at this edge, then pick the next ready
	always @(posedge clk) begin : result_sink
		result_t want;
		if (result.valid === 1'b1 && result.ready === 1'b1) begin
			if (pending_quotients.size() == 0) begin
				$error("quotient item with nothing owed: bits %h", result.quotient_bits);
				fail_count++;
			end else begin
				want = pending_quotients.pop_front();
				if (result.quotient_bits !== want.quotient_bits) begin
					$error("quotient_bits: expected %h, actual %h",
						want.quotient_bits, result.quotient_bits);
					fail_count++;
				end
				if (result.quotient_unsigned !== want.quotient_unsigned) begin
					$error("quotient_unsigned: expected %0d, actual %0d",
						want.quotient_unsigned, result.quotient_unsigned);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					fail_count++;
				end
			end
		end
		// a long hold-off lets the chain fill and push back on the operands side
		if (hold_left > 0) begin
			result.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// stimulus and end of run
	initial begin
		arst_n                     = 1'b0;
		psel                       = 1'b0;
		penable                    = 1'b0;
		pwrite                     = 1'b0;
		paddr                      = '0;
		pwdata                     = '0;
		operands.valid             = 1'b0;
		operands.dividend_bits     = '0;
		operands.dividend_unsigned = 1'b0;
		operands.dividend_null     = 1'b0;
		operands.divisor_bits      = '0;
		operands.divisor_unsigned  = 1'b0;
		operands.divisor_null      = 1'b0;
		result.ready               = 1'b0;
		zero_err_cfg               = 1'b0;
		fail_count                 = 0;
		send_idle_pct              = 0;
		recv_stall_pct             = 0;
		hold_left                  = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows, register changed between rows only once the block is idle
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed_rows[i].zero_err !== zero_err_cfg) begin
				drain_results();
				write_register(REG_ERROR_ON_ZERO_DIVISOR,
					{{(APB_DATA_WIDTH-1){1'b0}}, directed_rows[i].zero_err});
			end
			send_pair(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
		end

		// random batches: no idling, idle sender, stalling receiver, both, then back-pressure
		run_batch(390, 0, 0, 1'b0, 0);
		run_batch(390, 75, 0, 1'b1, 0);
		run_batch(390, 0, 75, 1'b0, 0);
		run_batch(390, 25, 25, 1'b1, 0);
		run_batch(370, 0, 10, 1'b0, 300);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_quotients.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
